// ===== hw/rtl/i2cm_pkg.sv =====
// shared types and constants of the i2c master bit engine
package i2cm_pkg;

    // field and register widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned DELAY_W   = 12;
    localparam int unsigned STRETCH_W = 16;
    localparam int unsigned BIT_IDX_W = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = STRETCH_W;

    // register reset values
    localparam logic [DELAY_W-1:0]   EDGE_DELAY_RESET    = 12'd42;
    localparam logic [STRETCH_W-1:0] STRETCH_LIMIT_RESET = 16'(3 * 230);

    // bits sent per byte before the acknowledge bit
    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_DELAY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_LIMIT = 1'd1;

    // configuration register contents
    typedef struct packed {
        logic [DELAY_W-1:0]   edge_delay_ticks;
        logic [STRETCH_W-1:0] stretch_limit;
    } cfg_t;

    // one input transaction
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
        logic              scl_in;
        logic              sda_in;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic scl_pull_low;
        logic sda_pull_low;
        logic busy_res;
        logic done_res;
        logic nack;
        logic bus_error;
    } result_t;

endpackage

// ===== hw/rtl/i2cm_cfg.sv =====
// configuration registers of the i2c master bit engine
module i2cm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output i2cm_pkg::cfg_t                   cfg
);

    logic [i2cm_pkg::DELAY_W-1:0]   edge_delay_reg;
    logic [i2cm_pkg::STRETCH_W-1:0] stretch_limit_reg;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_delay_reg    <= i2cm_pkg::EDGE_DELAY_RESET;
            stretch_limit_reg <= i2cm_pkg::STRETCH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cm_pkg::REG_EDGE_DELAY:
                    edge_delay_reg <= cfg_data[i2cm_pkg::DELAY_W-1:0];
                i2cm_pkg::REG_STRETCH_LIMIT:
                    stretch_limit_reg <= cfg_data[i2cm_pkg::STRETCH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.edge_delay_ticks = edge_delay_reg;
    assign cfg.stretch_limit    = stretch_limit_reg;

endmodule

// ===== hw/rtl/i2cm_seq.sv =====
// bus sequencer: advances the line state by one tick per transaction
module i2cm_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  i2cm_pkg::item_t    item,
    input  i2cm_pkg::cfg_t     cfg,
    output i2cm_pkg::result_t  res
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ST_CHK = 4'd1,
        PH_ST_W1  = 4'd2,
        PH_ST_W2  = 4'd3,
        PH_ST_W3  = 4'd4,
        PH_SP_W1  = 4'd5,
        PH_SP_W2  = 4'd6,
        PH_SP_W3  = 4'd7,
        PH_WR_LOW = 4'd8,
        PH_WR_STR = 4'd9,
        PH_WR_HI  = 4'd10,
        PH_AK_LOW = 4'd11,
        PH_AK_STR = 4'd12,
        PH_AK_HI  = 4'd13
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [i2cm_pkg::BIT_IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [i2cm_pkg::BYTE_W-1:0]     tx_shift_reg, tx_shift_next;
    logic [i2cm_pkg::DELAY_W-1:0]    delay_reg, delay_next;
    logic [i2cm_pkg::STRETCH_W-1:0]  stretch_reg, stretch_next;
    logic                            ack_reg, ack_next;
    logic                            scl_drive_reg, scl_drive_next;
    logic                            sda_drive_reg, sda_drive_next;
    logic                            wait_done;
    logic                            stretch_end;
    logic                            done;
    logic                            nack;
    logic                            berr;

    // end of the edge wait and of the clock stretch wait
    assign wait_done   = (delay_reg <= 12'd1);
    assign stretch_end = item.scl_in || (stretch_reg >= cfg.stretch_limit);

    // next state of the sequence for this tick
    always_comb
    begin
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        tx_shift_next  = tx_shift_reg;
        delay_next     = delay_reg;
        stretch_next   = stretch_reg;
        ack_next       = ack_reg;
        scl_drive_next = scl_drive_reg;
        sda_drive_next = sda_drive_reg;
        done           = 1'b0;
        nack           = 1'b0;
        berr           = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                case (item.cmd)
                    i2cm_pkg::CMD_START:
                    begin
                        scl_drive_next = 1'b0;
                        sda_drive_next = 1'b0;
                        phase_next     = PH_ST_CHK;
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        scl_drive_next = 1'b1;
                        sda_drive_next = 1'b1;
                        delay_next     = cfg.edge_delay_ticks;
                        phase_next     = PH_SP_W1;
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        tx_shift_next  = item.data_byte;
                        bit_index_next = '0;
                        scl_drive_next = 1'b1;
                        sda_drive_next = ~item.data_byte[i2cm_pkg::BYTE_W-1];
                        delay_next     = cfg.edge_delay_ticks;
                        phase_next     = PH_WR_LOW;
                    end
                    default:
                    begin
                    end
                endcase
            end
            PH_ST_CHK:
            begin
                if (!item.sda_in)
                begin
                    berr       = 1'b1;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    delay_next = cfg.edge_delay_ticks;
                    phase_next = PH_ST_W1;
                end
            end
            PH_ST_W1, PH_ST_W2, PH_SP_W1, PH_SP_W2:
            begin
                if (wait_done)
                begin
                    delay_next = cfg.edge_delay_ticks;
                    case (phase_reg)
                        PH_ST_W1:
                        begin
                            sda_drive_next = 1'b1;
                            phase_next     = PH_ST_W2;
                        end
                        PH_ST_W2:
                        begin
                            scl_drive_next = 1'b1;
                            phase_next     = PH_ST_W3;
                        end
                        PH_SP_W1:
                        begin
                            scl_drive_next = 1'b0;
                            phase_next     = PH_SP_W2;
                        end
                        default:
                        begin
                            sda_drive_next = 1'b0;
                            phase_next     = PH_SP_W3;
                        end
                    endcase
                end
                else
                begin
                    delay_next = delay_reg - 12'd1;
                end
            end
            PH_ST_W3, PH_SP_W3:
            begin
                if (wait_done)
                begin
                    delay_next = '0;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    delay_next = delay_reg - 12'd1;
                end
            end
            PH_WR_LOW, PH_AK_LOW:
            begin
                if (wait_done)
                begin
                    delay_next     = '0;
                    scl_drive_next = 1'b0;
                    stretch_next   = '0;
                    phase_next     = (phase_reg == PH_WR_LOW) ? PH_WR_STR : PH_AK_STR;
                end
                else
                begin
                    delay_next = delay_reg - 12'd1;
                end
            end
            PH_WR_STR, PH_AK_STR:
            begin
                if (stretch_end)
                begin
                    delay_next = cfg.edge_delay_ticks;
                    if (phase_reg == PH_AK_STR)
                    begin
                        ack_next   = item.sda_in;
                        phase_next = PH_AK_HI;
                    end
                    else
                    begin
                        phase_next = PH_WR_HI;
                    end
                end
                else
                begin
                    stretch_next = stretch_reg + 16'd1;
                end
            end
            PH_WR_HI:
            begin
                if (wait_done)
                begin
                    tx_shift_next  = {tx_shift_reg[i2cm_pkg::BYTE_W-2:0], 1'b0};
                    bit_index_next = bit_index_reg + 4'd1;
                    delay_next     = cfg.edge_delay_ticks;
                    scl_drive_next = 1'b1;
                    if (bit_index_next >= i2cm_pkg::BITS_PER_BYTE)
                    begin
                        sda_drive_next = 1'b0;
                        phase_next     = PH_AK_LOW;
                    end
                    else
                    begin
                        sda_drive_next = ~tx_shift_reg[i2cm_pkg::BYTE_W-2];
                        phase_next     = PH_WR_LOW;
                    end
                end
                else
                begin
                    delay_next = delay_reg - 12'd1;
                end
            end
            PH_AK_HI:
            begin
                if (wait_done)
                begin
                    delay_next = '0;
                    done       = 1'b1;
                    nack       = ack_reg;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    delay_next = delay_reg - 12'd1;
                end
            end
            default:
            begin
                scl_drive_next = 1'b0;
                sda_drive_next = 1'b0;
                phase_next     = PH_IDLE;
            end
        endcase
    end

    // sequence state, stepped once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= '0;
            tx_shift_reg  <= '0;
            delay_reg     <= '0;
            stretch_reg   <= '0;
            ack_reg       <= 1'b0;
            scl_drive_reg <= 1'b0;
            sda_drive_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            tx_shift_reg  <= tx_shift_next;
            delay_reg     <= delay_next;
            stretch_reg   <= stretch_next;
            ack_reg       <= ack_next;
            scl_drive_reg <= scl_drive_next;
            sda_drive_reg <= sda_drive_next;
        end
    end

    // result of this tick, showing the state after it
    assign res.scl_pull_low = scl_drive_next;
    assign res.sda_pull_low = sda_drive_next;
    assign res.busy_res     = (phase_next != PH_IDLE);
    assign res.done_res     = done;
    assign res.nack         = nack;
    assign res.bus_error    = berr;

endmodule

// ===== hw/rtl/i2c_master_bit_engine_unit.sv =====
// top level of the i2c master bit engine
//
// Open-drain I2C master sequencer. Every input transaction is one bus tick
// carrying the sampled SCL/SDA levels and an optional command (start, stop,
// write byte with acknowledge read), and every input transaction gives
// exactly one result transaction with the line drives and the busy, done,
// nack and bus error flags after that tick. One transaction is taken per
// clock cycle unless the output side stalls; a transaction goes from the
// input register to the result register, and the sequencer state steps
// once as it passes between them. Configuration registers are written
// through cfg_we, cfg_index and cfg_data and take effect on the next tick;
// write them only while the block is idle.
module i2c_master_bit_engine_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [i2cm_pkg::CMD_W-1:0]       cmd,
    input  logic [i2cm_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             scl_in,
    input  logic                             sda_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             scl_pull_low,
    output logic                             sda_pull_low,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             nack,
    output logic                             bus_error
);

    i2cm_pkg::cfg_t     cfg;
    i2cm_pkg::item_t    item_reg;
    i2cm_pkg::result_t  res_next;
    i2cm_pkg::result_t  res_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;

    i2cm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // move a transaction from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.cmd       <= cmd;
            item_reg.data_byte <= data_byte;
            item_reg.scl_in    <= scl_in;
            item_reg.sda_in    <= sda_in;
        end
    end

    i2cm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_pull_low = res_reg.scl_pull_low;
    assign sda_pull_low = res_reg.sda_pull_low;
    assign busy_res     = res_reg.busy_res;
    assign done_res     = res_reg.done_res;
    assign nack         = res_reg.nack;
    assign bus_error    = res_reg.bus_error;

endmodule
